// ----- design/iirbq_pkg.sv -----
// Package for the biquad IIR section: widths, payload structs, register map,
// controller states and datapath command struct. No dependencies.
`timescale 1ns / 1ps

package iirbq_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned COEF_FRAC_BITS = 15;
  localparam int unsigned COEF_W         = 18;
  localparam int unsigned STATE_W        = 32;
  localparam int unsigned PROD_W         = COEF_W + SAMPLE_BITS;
  // headroom for state + two products
  localparam int unsigned ACC_W          = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 3;
  localparam int unsigned APB_AW         = 5;
  localparam int unsigned APB_DW         = 32;

  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_W-1:0]     state_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  localparam coef_t B0_RESET = COEF_W'(1 << COEF_FRAC_BITS);

  typedef struct packed {
    sample_t sample_in;
    logic    block_start;
  } in_item_t;

  typedef struct packed {
    sample_t sample_out;
    logic    clipped;
  } out_item_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
    coef_t base_first;
    coef_t base_second;
  } coef_bank_t;

  typedef enum logic [2:0] {
    REG_B0          = 3'd0,
    REG_B1          = 3'd1,
    REG_B2          = 3'd2,
    REG_A1          = 3'd3,
    REG_A2          = 3'd4,
    REG_BASE_FIRST  = 3'd5,
    REG_BASE_SECOND = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2,
    COEF_BASE_FIRST,
    COEF_BASE_SECOND
  } coef_sel_e;

  typedef enum logic [1:0] {
    ADD_ZERO,
    ADD_Z0,
    ADD_Z1,
    ADD_ACC
  } addend_sel_e;

  typedef enum logic {
    MUL_X,
    MUL_Y
  } mul_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE0,
    ST_BASE1,
    ST_BASE2,
    ST_MAC_Y,
    ST_MAC_Z0A,
    ST_MAC_Z0B,
    ST_MAC_Z1A,
    ST_MAC_Z1B,
    ST_FINISH
  } state_e;

  typedef struct packed {
    coef_sel_e   coef_sel;
    mul_src_e    mul_src;
    logic        negate;
    addend_sel_e addend;
    logic        load_acc;
    logic        load_x;
    logic        clr_hit;
    logic        load_y;
    logic        load_z0;
    logic        load_z1;
    logic        load_out;
  } cmd_t;

endpackage

// ----- design/iirbq_dp.sv -----
// Datapath of the biquad section: shared multiply-accumulate, rounding and
// saturation, delay states and output register. Uses iirbq_pkg.
`timescale 1ns / 1ps

module iirbq_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iirbq_pkg::cmd_t       cmd_i,
  input  iirbq_pkg::coef_bank_t coefs_i,
  input  iirbq_pkg::in_item_t   in_data_i,
  output iirbq_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW = iirbq_pkg::ACC_W;
  localparam int unsigned SW = iirbq_pkg::STATE_W;
  localparam int unsigned NB = iirbq_pkg::SAMPLE_BITS;
  localparam int unsigned PW = iirbq_pkg::PROD_W;
  localparam logic [AW:0] RND_HALF = (AW+1)'(1) << (iirbq_pkg::COEF_FRAC_BITS - 1);

  iirbq_pkg::sample_t   x_q, y_q, y_sat;
  iirbq_pkg::acc_t      acc_q, acc_d, addend, term;
  iirbq_pkg::state_t    z0_q, z1_q, z_sat;
  iirbq_pkg::coef_t     coef;
  iirbq_pkg::sample_t   mul_b;
  iirbq_pkg::out_item_t out_q;
  logic signed [PW-1:0] prod;
  logic signed [AW:0]   rnd, shifted;
  logic                 hit_q, hit_d;
  logic                 z_over, y_over;
  logic [AW-SW:0]       z_top;
  logic [AW-NB+1:0]     y_top;

  // operand select and MAC
  always_comb begin
    case (cmd_i.coef_sel)
      iirbq_pkg::COEF_B0:          coef = coefs_i.b0;
      iirbq_pkg::COEF_B1:          coef = coefs_i.b1;
      iirbq_pkg::COEF_B2:          coef = coefs_i.b2;
      iirbq_pkg::COEF_A1:          coef = coefs_i.a1;
      iirbq_pkg::COEF_A2:          coef = coefs_i.a2;
      iirbq_pkg::COEF_BASE_FIRST:  coef = coefs_i.base_first;
      iirbq_pkg::COEF_BASE_SECOND: coef = coefs_i.base_second;
      default:                     coef = coefs_i.b0;
    endcase
    mul_b = (cmd_i.mul_src == iirbq_pkg::MUL_Y) ? y_q : x_q;
    prod  = coef * mul_b;
    term  = {{(AW-PW){prod[PW-1]}}, prod};
    if (cmd_i.negate) begin
      term = -term;
    end
    case (cmd_i.addend)
      iirbq_pkg::ADD_ZERO: addend = '0;
      iirbq_pkg::ADD_Z0:   addend = {{(AW-SW){z0_q[SW-1]}}, z0_q};
      iirbq_pkg::ADD_Z1:   addend = {{(AW-SW){z1_q[SW-1]}}, z1_q};
      iirbq_pkg::ADD_ACC:  addend = acc_q;
      default:             addend = '0;
    endcase
    acc_d = addend + term;
  end

  // state saturation from the accumulator
  always_comb begin
    z_top  = acc_q[AW-1:SW-1];
    z_over = !((&z_top) || !(|z_top));
    if (z_over) begin
      z_sat = acc_q[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      z_sat = acc_q[SW-1:0];
    end
  end

  // output: round half up, floor shift, saturate
  always_comb begin
    rnd     = $signed({acc_q[AW-1], acc_q}) + $signed(RND_HALF);
    shifted = rnd >>> iirbq_pkg::COEF_FRAC_BITS;
    y_top   = shifted[AW:NB-1];
    y_over  = !((&y_top) || !(|y_top));
    if (y_over) begin
      y_sat = shifted[AW] ? {1'b1, {(NB-1){1'b0}}} : {1'b0, {(NB-1){1'b1}}};
    end else begin
      y_sat = shifted[NB-1:0];
    end
  end

  always_comb begin
    if (cmd_i.clr_hit) begin
      hit_d = 1'b0;
    end else begin
      hit_d = hit_q | (cmd_i.load_y & y_over) |
              ((cmd_i.load_z0 | cmd_i.load_z1) & z_over);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z0_q  <= '0;
      z1_q  <= '0;
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
      if (cmd_i.load_z0) begin
        z0_q <= z_sat;
      end
      if (cmd_i.load_z1) begin
        z1_q <= z_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= in_data_i.sample_in;
    end
    if (cmd_i.load_acc) begin
      acc_q <= acc_d;
    end
    if (cmd_i.load_y) begin
      y_q <= y_sat;
    end
    if (cmd_i.load_out) begin
      out_q.sample_out <= y_q;
      out_q.clipped    <= hit_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- design/iirbq_ctrl.sv -----
// Sequencer for the biquad section: handshakes and MAC schedule.
// Uses iirbq_pkg; drives the iirbq_dp command struct.
`timescale 1ns / 1ps

module iirbq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_start_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iirbq_pkg::cmd_t cmd_o
);

  iirbq_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      iirbq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_start_i ? iirbq_pkg::ST_BASE0 : iirbq_pkg::ST_MAC_Y;
        end
      end
      iirbq_pkg::ST_BASE0:   state_d = iirbq_pkg::ST_BASE1;
      iirbq_pkg::ST_BASE1:   state_d = iirbq_pkg::ST_BASE2;
      iirbq_pkg::ST_BASE2:   state_d = iirbq_pkg::ST_MAC_Z0A;
      iirbq_pkg::ST_MAC_Y:   state_d = iirbq_pkg::ST_MAC_Z0A;
      iirbq_pkg::ST_MAC_Z0A: state_d = iirbq_pkg::ST_MAC_Z0B;
      iirbq_pkg::ST_MAC_Z0B: state_d = iirbq_pkg::ST_MAC_Z1A;
      iirbq_pkg::ST_MAC_Z1A: state_d = iirbq_pkg::ST_MAC_Z1B;
      iirbq_pkg::ST_MAC_Z1B: state_d = iirbq_pkg::ST_FINISH;
      iirbq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = iirbq_pkg::ST_IDLE;
        end
      end
      default: state_d = iirbq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.coef_sel = iirbq_pkg::COEF_B0;
    cmd_o.mul_src  = iirbq_pkg::MUL_X;
    cmd_o.addend   = iirbq_pkg::ADD_ZERO;
    in_ready_o     = 1'b0;
    unique case (state_q)
      iirbq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_x  = in_valid_i;
        cmd_o.clr_hit = in_valid_i;
      end
      iirbq_pkg::ST_BASE0: begin
        cmd_o.coef_sel = iirbq_pkg::COEF_BASE_FIRST;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_BASE1: begin
        cmd_o.load_z0  = 1'b1;
        cmd_o.coef_sel = iirbq_pkg::COEF_BASE_SECOND;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_BASE2: begin
        cmd_o.load_z1  = 1'b1;
        cmd_o.coef_sel = iirbq_pkg::COEF_B0;
        cmd_o.addend   = iirbq_pkg::ADD_Z0;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_MAC_Y: begin
        cmd_o.coef_sel = iirbq_pkg::COEF_B0;
        cmd_o.addend   = iirbq_pkg::ADD_Z0;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_MAC_Z0A: begin
        cmd_o.load_y   = 1'b1;
        cmd_o.coef_sel = iirbq_pkg::COEF_B1;
        cmd_o.addend   = iirbq_pkg::ADD_Z1;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_MAC_Z0B: begin
        cmd_o.coef_sel = iirbq_pkg::COEF_A1;
        cmd_o.mul_src  = iirbq_pkg::MUL_Y;
        cmd_o.negate   = 1'b1;
        cmd_o.addend   = iirbq_pkg::ADD_ACC;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_MAC_Z1A: begin
        cmd_o.load_z0  = 1'b1;
        cmd_o.coef_sel = iirbq_pkg::COEF_B2;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_MAC_Z1B: begin
        cmd_o.coef_sel = iirbq_pkg::COEF_A2;
        cmd_o.mul_src  = iirbq_pkg::MUL_Y;
        cmd_o.negate   = 1'b1;
        cmd_o.addend   = iirbq_pkg::ADD_ACC;
        cmd_o.load_acc = 1'b1;
      end
      iirbq_pkg::ST_FINISH: begin
        cmd_o.load_z1  = out_free;
        cmd_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iirbq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/iir_biquad_filter.sv -----
// Top level of the biquad IIR section: APB register file and the
// controller/datapath pair. Depends on iirbq_pkg, iirbq_ctrl, iirbq_dp.
`timescale 1ns / 1ps

// Second-order IIR section, transposed direct form II, fixed point.
// Input channel (in_valid_i/in_ready_o, in_data_i): one signed sample plus a
//   block_start flag; with block_start set, both delay states are first loaded
//   with the base registers times the sample (saturated to 32 bits).
// Output channel (out_valid_o/out_ready_i, out_data_o): the rounded and
//   saturated sample and a clipped flag covering output, start load and state
//   saturation for that sample.
// Timing: one shared 18x16 multiply-accumulate unit does all products, one per
//   cycle. After its transfer a sample passes through MAC_Y (BASE0 to BASE2
//   with block_start), then MAC_Z0A, MAC_Z0B, MAC_Z1A, MAC_Z1B and FINISH, which
//   loads the output register; only back in idle is the next sample taken.
// The output register decouples the sides: a new sample is taken while the
//   last result waits; if the receiver stalls, the sequencer holds in its last
//   step, back-pressuring the input, until the output register frees up.
// Reset: delay states clear to zero, b0 = 1.0, all other registers zero,
//   no result pending.
// Config: APB, registers at 4*i (b0, b1, b2, a1, a2, base_first,
//   base_second), low 18 bits taken, reads sign-extended. Write only while idle.

module iir_biquad_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  iirbq_pkg::in_item_t          in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output iirbq_pkg::out_item_t         out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [iirbq_pkg::APB_AW-1:0] paddr,
  input  logic [iirbq_pkg::APB_DW-1:0] pwdata,
  output logic [iirbq_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);

  localparam int unsigned CW = iirbq_pkg::COEF_W;

  iirbq_pkg::coef_bank_t coefs_q;
  iirbq_pkg::cmd_t       cmd;
  iirbq_pkg::reg_idx_e   reg_idx;
  iirbq_pkg::coef_t      rd_val;
  logic                  reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = iirbq_pkg::reg_idx_e'(paddr[4:2]);
  assign reg_wr  = psel && penable && pwrite;

  // register write, low 18 bits only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q             <= '{b0: iirbq_pkg::B0_RESET, default: '0};
    end else if (reg_wr) begin
      unique case (reg_idx)
        iirbq_pkg::REG_B0:          coefs_q.b0          <= pwdata[CW-1:0];
        iirbq_pkg::REG_B1:          coefs_q.b1          <= pwdata[CW-1:0];
        iirbq_pkg::REG_B2:          coefs_q.b2          <= pwdata[CW-1:0];
        iirbq_pkg::REG_A1:          coefs_q.a1          <= pwdata[CW-1:0];
        iirbq_pkg::REG_A2:          coefs_q.a2          <= pwdata[CW-1:0];
        iirbq_pkg::REG_BASE_FIRST:  coefs_q.base_first  <= pwdata[CW-1:0];
        iirbq_pkg::REG_BASE_SECOND: coefs_q.base_second <= pwdata[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // readback, unmapped addresses read zero
  always_comb begin
    unique case (reg_idx)
      iirbq_pkg::REG_B0:          rd_val = coefs_q.b0;
      iirbq_pkg::REG_B1:          rd_val = coefs_q.b1;
      iirbq_pkg::REG_B2:          rd_val = coefs_q.b2;
      iirbq_pkg::REG_A1:          rd_val = coefs_q.a1;
      iirbq_pkg::REG_A2:          rd_val = coefs_q.a2;
      iirbq_pkg::REG_BASE_FIRST:  rd_val = coefs_q.base_first;
      iirbq_pkg::REG_BASE_SECOND: rd_val = coefs_q.base_second;
      default:                    rd_val = '0;
    endcase
    prdata = {{(iirbq_pkg::APB_DW-CW){rd_val[CW-1]}}, rd_val};
  end

  iirbq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_start_i  (in_data_i.block_start),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  iirbq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .coefs_i    (coefs_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // a transfer in starts work; no second sample is taken on the next edge
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample taken while previous one still in work");

  // result register is only overwritten when empty or being drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("finished result not presented");

  // delay states must not move while waiting for input
  a_idle_states_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.load_z0 || cmd.load_z1 || cmd.load_out))
    else $error("state update while idle");

endmodule

// ----- dv/iirbq_checker.sv -----
// Checker for the biquad IIR section: watches the APB, input and output channels,
// predicts each result and compares it with what the block returns. Depends on iirbq_pkg.
`timescale 1ns / 1ps

module iirbq_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  iirbq_pkg::in_item_t          in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  iirbq_pkg::out_item_t         out_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [iirbq_pkg::APB_AW-1:0] paddr_i,
  input  logic [iirbq_pkg::APB_DW-1:0] pwdata_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  localparam longint STATE_HI  = (longint'(1) <<< (iirbq_pkg::STATE_W - 1)) - 1;
  localparam longint STATE_LO  = -(longint'(1) <<< (iirbq_pkg::STATE_W - 1));
  localparam longint SAMPLE_HI = (longint'(1) <<< (iirbq_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (iirbq_pkg::SAMPLE_BITS - 1));
  localparam int unsigned CW   = iirbq_pkg::COEF_W;

  iirbq_pkg::coef_bank_t coefs;
  longint                delay_line [2];
  iirbq_pkg::out_item_t  predicted_outputs [$];
  int                    mismatches = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // One step of the section; updates delay_line as a side effect.
  function automatic iirbq_pkg::out_item_t filter_sample(iirbq_pkg::in_item_t item);
    longint               x, acc, y, z0, z1, load0, load1;
    logic                 hit;
    iirbq_pkg::out_item_t res;
    x   = longint'($signed(item.sample_in));
    hit = 1'b0;
    if (item.block_start) begin
      load0         = longint'($signed(coefs.base_first)) * x;
      load1         = longint'($signed(coefs.base_second)) * x;
      delay_line[0] = clamp(load0, STATE_LO, STATE_HI);
      delay_line[1] = clamp(load1, STATE_LO, STATE_HI);
      hit |= (delay_line[0] != load0) || (delay_line[1] != load1);
    end
    acc = longint'($signed(coefs.b0)) * x + delay_line[0];
    // round half up, arithmetic shift floors
    y   = (acc + (longint'(1) <<< (iirbq_pkg::COEF_FRAC_BITS - 1)))
          >>> iirbq_pkg::COEF_FRAC_BITS;
    hit |= (y > SAMPLE_HI) || (y < SAMPLE_LO);
    y   = clamp(y, SAMPLE_LO, SAMPLE_HI);
    // feedback uses the saturated output
    z0  = delay_line[1] + longint'($signed(coefs.b1)) * x
          - longint'($signed(coefs.a1)) * y;
    z1  = longint'($signed(coefs.b2)) * x - longint'($signed(coefs.a2)) * y;
    delay_line[0] = clamp(z0, STATE_LO, STATE_HI);
    delay_line[1] = clamp(z1, STATE_LO, STATE_HI);
    hit |= (delay_line[0] != z0) || (delay_line[1] != z1);
    res.sample_out = iirbq_pkg::sample_t'(y);
    res.clipped    = hit;
    return res;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    iirbq_pkg::out_item_t want;
    if (!rst_ni) begin
      coefs         = '0;
      coefs.b0      = iirbq_pkg::B0_RESET;
      delay_line[0] = 0;
      delay_line[1] = 0;
      predicted_outputs.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (iirbq_pkg::reg_idx_e'(paddr_i[iirbq_pkg::APB_AW-1:2]))
          iirbq_pkg::REG_B0:
            coefs.b0          = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_B1:
            coefs.b1          = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_B2:
            coefs.b2          = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_A1:
            coefs.a1          = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_A2:
            coefs.a2          = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_BASE_FIRST:
            coefs.base_first  = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          iirbq_pkg::REG_BASE_SECOND:
            coefs.base_second = iirbq_pkg::coef_t'(pwdata_i[CW-1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_outputs.size() == 0) begin
          report("output transfer with no sample outstanding");
        end else begin
          want = predicted_outputs.pop_front();
          if (out_data_i.sample_out !== want.sample_out)
            report($sformatf("sample_out expected %0d, got %0d",
                             want.sample_out, $signed(out_data_i.sample_out)));
          if (out_data_i.clipped !== want.clipped)
            report($sformatf("clipped expected %0b, got %0b",
                             want.clipped, out_data_i.clipped));
        end
      end
      if (in_valid_i && in_ready_i)
        predicted_outputs = {predicted_outputs, filter_sample(in_data_i)};
    end
    mismatch_count_o <= mismatches;
    pending_o        <= predicted_outputs.size();
  end

endmodule

// ----- dv/iir_biquad_filter_test.sv -----
// Testbench top for the biquad IIR section: clock, reset, APB setup, sample
// stimulus and receiver stalls; verdict from iirbq_checker. Depends on iirbq_pkg.
`timescale 1ns / 1ps

module iir_biquad_filter_test;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int RANDOM_PHASES     = 11;
  localparam int SAMPLES_PER_PHASE = 100;
  localparam int QUIET_PHASES      = 2;   // tail of the run with no idling
  localparam int DRAIN_MARGIN      = 16;  // extra wait past the last result
  localparam int unsigned CW       = iirbq_pkg::COEF_W;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  iirbq_pkg::in_item_t           in_data;
  logic                          out_valid;
  logic                          out_ready;
  iirbq_pkg::out_item_t          out_data;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [iirbq_pkg::APB_AW-1:0]  paddr;
  logic [iirbq_pkg::APB_DW-1:0]  pwdata;
  logic [iirbq_pkg::APB_DW-1:0]  prdata;
  logic                          pready;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  int idle_pct    = 0;  // chance in percent that a side starts an idle burst
  int stall_left  = 0;

  always #2 clk = ~clk;

  iir_biquad_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  iirbq_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: ready drops in random bursts while idle_pct is nonzero.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(10, 1) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // APB write: setup cycle, then access until pready. Upper bits of pwdata
  // get junk, since the block only keeps the low COEF_W bits.
  task automatic write_reg(input iirbq_pkg::reg_idx_e idx, input iirbq_pkg::coef_t value);
    logic [iirbq_pkg::APB_DW-1:0] word;
    word          = $urandom;
    word[CW-1:0]  = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_bank(input iirbq_pkg::coef_bank_t bank);
    write_reg(iirbq_pkg::REG_B0,          bank.b0);
    write_reg(iirbq_pkg::REG_B1,          bank.b1);
    write_reg(iirbq_pkg::REG_B2,          bank.b2);
    write_reg(iirbq_pkg::REG_A1,          bank.a1);
    write_reg(iirbq_pkg::REG_A2,          bank.a2);
    write_reg(iirbq_pkg::REG_BASE_FIRST,  bank.base_first);
    write_reg(iirbq_pkg::REG_BASE_SECOND, bank.base_second);
  endtask

  // Offer one sample, possibly after an idle burst; returns once transferred.
  // Valid stays high into the next call unless that call idles first.
  task automatic send_sample(input iirbq_pkg::sample_t x, input logic start);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(10, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{sample_in: x, block_start: start};
    do @(posedge clk); while (!in_ready);
  endtask

  // Quiesce: drop valid, wait until every predicted result has come back and
  // the block takes input again. Registers are only written after this.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !in_ready);
  endtask

  initial begin : stimulus
    iirbq_pkg::coef_bank_t bank;
    iirbq_pkg::sample_t    x;
    logic                  start;
    in_valid = 1'b0;
    in_data  = '0;
    out_ready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    idle_pct = 20;
    // Reset coefficients: b0 = 1.0, output follows input; full-scale samples.
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shffff, 1'b0);
    drain();

    // Every register at its positive extreme: start load, output and state
    // all saturate.
    write_bank({7{18'sh1ffff}});
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    drain();

    // Negative extreme; base * most negative sample overflows upward.
    write_bank({7{18'sh20000}});
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    drain();

    // All zero: output must be zero whatever the input.
    write_bank('0);
    send_sample(16'sh3039, 1'b1);
    send_sample(16'shffff, 1'b0);
    drain();

    // Tiny b0 exercises the half-up rounding at +/- half an LSB.
    bank            = '0;
    bank.b0         = 18'sd1;
    bank.base_first = 18'sd1;
    write_bank(bank);
    send_sample(16'shc000, 1'b1);
    send_sample(16'sh4000, 1'b0);
    send_sample(16'shc000, 1'b0);
    send_sample(16'sh3fff, 1'b0);
    send_sample(16'shbfff, 1'b0);
    drain();

    // A plausible low-pass with a steady-state start.
    bank.b0          = 18'sd1024;
    bank.b1          = 18'sd2048;
    bank.b2          = 18'sd1024;
    bank.a1          = -18'sd52000;
    bank.a2          = 18'sd21000;
    bank.base_first  = 18'sd31000;
    bank.base_second = -18'sd20000;
    write_bank(bank);
    send_sample(16'sh1000, 1'b1);
    send_sample(16'sh1000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    drain();

    // --- random part ---
    // Mostly tame filters (small feedforward, a1 negative, a2 positive) so the
    // recursion runs long; a random one phase in four takes full-range values.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(3) == 0) begin
        bank.b0          = iirbq_pkg::coef_t'($urandom);
        bank.b1          = iirbq_pkg::coef_t'($urandom);
        bank.b2          = iirbq_pkg::coef_t'($urandom);
        bank.a1          = iirbq_pkg::coef_t'($urandom);
        bank.a2          = iirbq_pkg::coef_t'($urandom);
        bank.base_first  = iirbq_pkg::coef_t'($urandom);
        bank.base_second = iirbq_pkg::coef_t'($urandom);
      end else begin
        bank.b0          = iirbq_pkg::coef_t'(int'($urandom_range(16384)) - 8192);
        bank.b1          = iirbq_pkg::coef_t'(int'($urandom_range(16384)) - 8192);
        bank.b2          = iirbq_pkg::coef_t'(int'($urandom_range(16384)) - 8192);
        bank.a1          = iirbq_pkg::coef_t'(-int'($urandom_range(65536)));
        bank.a2          = iirbq_pkg::coef_t'($urandom_range(32000));
        bank.base_first  = iirbq_pkg::coef_t'(int'($urandom_range(65536)) - 32768);
        bank.base_second = iirbq_pkg::coef_t'(int'($urandom_range(65536)) - 32768);
      end
      write_bank(bank);

      if (phase >= RANDOM_PHASES - QUIET_PHASES) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end

      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        case ($urandom_range(7))
          0:       x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          1, 2:    x = iirbq_pkg::sample_t'(int'($urandom_range(512)) - 256);
          default: x = iirbq_pkg::sample_t'($urandom);
        endcase
        // Each phase opens with a steady-state start; restarts now and then.
        start = (n == 0) || ($urandom_range(19) == 0);
        send_sample(x, start);
      end
      drain();
    end

    repeat (DRAIN_MARGIN) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/iirbq_pkg.sv
design/iirbq_dp.sv
design/iirbq_ctrl.sv
design/iir_biquad_filter.sv
dv/iirbq_checker.sv
dv/iir_biquad_filter_test.sv
